>>> hdl/dual_number_alu_defines.svh
// Assertion macros used by dual_number_alu.sv to check this block.
`ifndef DUAL_NUMBER_ALU_DEFINES_SVH
`define DUAL_NUMBER_ALU_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define DNA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checks that a result beat with the given flag carries zero parts and no overflow.
`define DNA_ZERO_WHEN(lbl, flag, msg) \
    `DNA_ASSERT(lbl, (m_valid && (flag)) |-> (m_result_real == 32'sd0 && \
        m_result_dual == 32'sd0 && !m_overflow), msg)

`endif

>>> hdl/dna_pkg.sv
package dna_pkg;

    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_NEG = 3'd4;
    localparam logic [2:0] ACT_CMP = 3'd5;

    localparam int QUOT_BITS = 33;

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } sat_t;

    typedef struct packed {
        logic [31:0] res_real;
        logic [31:0] res_dual;
        logic        eq;
        logic        derr;
        logic        ovf;
        logic        is_div;
        logic        neg_r;
        logic        neg_d;
    } early_t;

    function automatic sat_t sat33(input logic [32:0] s);
        sat_t r;
        r.ovf = s[32] != s[31];
        r.val = r.ovf ? (s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : s[31:0];
        return r;
    endfunction

    function automatic sat_t sat_mag64(input logic neg, input logic [63:0] mag);
        sat_t r;
        if (neg) begin
            r.ovf = (|mag[63:32]) || (mag[31] && (|mag[30:0]));
            r.val = r.ovf ? 32'h8000_0000 : (32'd0 - mag[31:0]);
        end else begin
            r.ovf = |mag[63:31];
            r.val = r.ovf ? 32'h7FFF_FFFF : mag[31:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/dna_div.sv
module dna_div #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int QW = 33
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] q,
    output logic          big
);

    logic [DW-1:0] rem_reg [QW+1];
    logic [QW-1:0] low_reg [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic [DW-1:0] den_reg [QW+1];
    logic          big_reg [QW+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= DW'(num >> QW);
            low_reg[0] <= num[QW-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            big_reg[0] <= (NW+DW)'(num >> QW) >= (NW+DW)'(den);
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;
        assign trial = {rem_reg[k], low_reg[k][QW-1]};
        assign diff  = trial - {1'b0, den_reg[k]};
        assign ge    = trial >= {1'b0, den_reg[k]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                low_reg[k+1] <= {low_reg[k][QW-2:0], 1'b0};
                q_reg[k+1]   <= {q_reg[k][QW-2:0], ge};
                den_reg[k+1] <= den_reg[k];
                big_reg[k+1] <= big_reg[k];
            end
        end
    end

    assign q   = q_reg[QW];
    assign big = big_reg[QW];

endmodule

>>> hdl/dna_front.sv
module dna_front import dna_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   s_valid,
    input  logic [2:0]             s_action,
    input  logic signed [31:0]     s_first_real,
    input  logic signed [31:0]     s_first_dual,
    input  logic signed [31:0]     s_second_real,
    input  logic signed [31:0]     s_second_dual,
    output logic                   f_valid,
    output early_t                 f_early,
    output logic [32+FRAC_BITS-1:0] f_num_r,
    output logic [31:0]            f_den_r,
    output logic [64+FRAC_BITS-1:0] f_num_d,
    output logic [63:0]            f_den_d
);

    logic        v1_reg;
    logic [2:0]  act_reg;
    logic        sa1_reg, sb1_reg, sa2_reg, sb2_reg;
    logic [31:0] ma1_reg, ma2_reg;
    logic [63:0] paa_reg, pab_reg, pba_reg, psq_reg;
    logic [32:0] sum_r_reg, sum_d_reg, neg_r_reg, neg_d_reg;
    logic        eq_reg, z2_reg;

    logic [31:0] ma1, mb1, ma2, mb2;
    logic [32:0] xa1, xb1, xa2, xb2;

    assign ma1 = s_first_real[31]  ? 32'd0 - s_first_real  : s_first_real;
    assign mb1 = s_first_dual[31]  ? 32'd0 - s_first_dual  : s_first_dual;
    assign ma2 = s_second_real[31] ? 32'd0 - s_second_real : s_second_real;
    assign mb2 = s_second_dual[31] ? 32'd0 - s_second_dual : s_second_dual;
    assign xa1 = {s_first_real[31], s_first_real};
    assign xb1 = {s_first_dual[31], s_first_dual};
    assign xa2 = {s_second_real[31], s_second_real};
    assign xb2 = {s_second_dual[31], s_second_dual};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            f_valid <= 1'b0;
        end else if (en) begin
            v1_reg  <= s_valid;
            f_valid <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act_reg   <= s_action;
            sa1_reg   <= s_first_real[31];
            sb1_reg   <= s_first_dual[31];
            sa2_reg   <= s_second_real[31];
            sb2_reg   <= s_second_dual[31];
            ma1_reg   <= ma1;
            ma2_reg   <= ma2;
            paa_reg   <= 64'(ma1) * 64'(ma2);
            pab_reg   <= 64'(ma1) * 64'(mb2);
            pba_reg   <= 64'(ma2) * 64'(mb1);
            psq_reg   <= 64'(ma2) * 64'(ma2);
            sum_r_reg <= (s_action == ACT_ADD) ? xa1 + xa2 : xa1 - xa2;
            sum_d_reg <= (s_action == ACT_ADD) ? xb1 + xb2 : xb1 - xb2;
            neg_r_reg <= 33'd0 - xa1;
            neg_d_reg <= 33'd0 - xb1;
            eq_reg    <= (s_first_real == s_second_real) && (s_first_dual == s_second_dual);
            z2_reg    <= s_second_real == 32'sd0;
        end
    end

    logic        is_div, n1, n2, neg_sum;
    logic [63:0] m1, m2, mag;
    sat_t        sr, sd;
    early_t      early;

    always_comb begin
        is_div = act_reg == ACT_DIV;
        n1 = is_div ? (sa2_reg ^ sb1_reg) : (sa1_reg ^ sb2_reg);
        m1 = is_div ? pba_reg : pab_reg;
        n2 = is_div ? ~(sa1_reg ^ sb2_reg) : (sa2_reg ^ sb1_reg);
        m2 = is_div ? pab_reg : pba_reg;
        if (n1 == n2) begin
            neg_sum = n1;
            mag     = m1 + m2;
        end else if (m1 >= m2) begin
            neg_sum = n1;
            mag     = m1 - m2;
        end else begin
            neg_sum = n2;
            mag     = m2 - m1;
        end
    end

    always_comb begin
        early = '0;
        sr    = '0;
        sd    = '0;
        case (act_reg)
            ACT_ADD, ACT_SUB: begin
                sr = sat33(sum_r_reg);
                sd = sat33(sum_d_reg);
            end
            ACT_MUL: begin
                sr = sat_mag64(sa1_reg ^ sa2_reg, paa_reg >> FRAC_BITS);
                sd = sat_mag64(neg_sum, mag >> FRAC_BITS);
            end
            ACT_NEG: begin
                sr = sat33(neg_r_reg);
                sd = sat33(neg_d_reg);
            end
            ACT_DIV: begin
                early.derr   = z2_reg;
                early.is_div = !z2_reg;
                early.neg_r  = sa1_reg ^ sa2_reg;
                early.neg_d  = neg_sum;
            end
            ACT_CMP: begin
                early.eq = eq_reg;
            end
            default: begin
                early = '0;
            end
        endcase
        early.res_real = sr.val;
        early.res_dual = sd.val;
        early.ovf      = sr.ovf | sd.ovf;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_early <= early;
            f_num_r <= {ma1_reg, {FRAC_BITS{1'b0}}};
            f_den_r <= ma2_reg;
            f_num_d <= {mag, {FRAC_BITS{1'b0}}};
            f_den_d <= psq_reg;
        end
    end

endmodule

>>> hdl/dual_number_alu.sv
// Channel   Ports      Beat contents
// input     s_*        action, first_real, first_dual, second_real, second_dual
// result    m_*        result_real, result_dual, is_equal, divide_error, overflow
//
// One beat is accepted per cycle while the result port does not stall.
// Each beat passes through the 33 one-bit steps of the two quotient pipelines.
// Reset is synchronous and clears only the valid bits of every stage.
// A stall at the result port freezes all stages together, so nothing is lost.
`include "dual_number_alu_defines.svh"

module dual_number_alu import dna_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_action,
    input  logic signed [31:0] s_first_real,
    input  logic signed [31:0] s_first_dual,
    input  logic signed [31:0] s_second_real,
    input  logic signed [31:0] s_second_dual,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result_real,
    output logic signed [31:0] m_result_dual,
    output logic               m_is_equal,
    output logic               m_divide_error,
    output logic               m_overflow
);

    localparam int DIV_LAT = QUOT_BITS + 1;

    logic                    en;
    logic                    f_valid;
    early_t                  f_early;
    logic [32+FRAC_BITS-1:0] f_num_r;
    logic [31:0]             f_den_r;
    logic [64+FRAC_BITS-1:0] f_num_d;
    logic [63:0]             f_den_d;
    logic [QUOT_BITS-1:0]    q_r, q_d;
    logic                    big_r, big_d;

    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    dna_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en), .s_valid(s_valid),
        .s_action(s_action), .s_first_real(s_first_real), .s_first_dual(s_first_dual),
        .s_second_real(s_second_real), .s_second_dual(s_second_dual),
        .f_valid(f_valid), .f_early(f_early), .f_num_r(f_num_r), .f_den_r(f_den_r),
        .f_num_d(f_num_d), .f_den_d(f_den_d)
    );

    dna_div #(.NW(32+FRAC_BITS), .DW(32), .QW(QUOT_BITS)) u_div_real (
        .aclk(aclk), .en(en), .num(f_num_r), .den(f_den_r), .q(q_r), .big(big_r)
    );

    dna_div #(.NW(64+FRAC_BITS), .DW(64), .QW(QUOT_BITS)) u_div_dual (
        .aclk(aclk), .en(en), .num(f_num_d), .den(f_den_d), .q(q_d), .big(big_d)
    );

    logic   v_reg  [DIV_LAT];
    early_t sb_reg [DIV_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                v_reg[k] <= 1'b0;
            end
            m_valid <= 1'b0;
        end else if (en) begin
            v_reg[0] <= f_valid;
            for (int k = 1; k < DIV_LAT; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
            m_valid <= v_reg[DIV_LAT-1];
        end
    end

    early_t sb;
    sat_t   dr, dd;
    logic [31:0] res_real_next, res_dual_next;
    logic        ovf_next;

    assign sb = sb_reg[DIV_LAT-1];

    always_comb begin
        dr = sat_mag64(sb.neg_r, 64'(q_r) | {64{big_r}});
        dd = sat_mag64(sb.neg_d, 64'(q_d) | {64{big_d}});
        if (sb.is_div) begin
            res_real_next = dr.val;
            res_dual_next = dd.val;
            ovf_next      = dr.ovf | dd.ovf;
        end else begin
            res_real_next = sb.res_real;
            res_dual_next = sb.res_dual;
            ovf_next      = sb.ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[0] <= f_early;
            for (int k = 1; k < DIV_LAT; k++) begin
                sb_reg[k] <= sb_reg[k-1];
            end
            m_result_real  <= res_real_next;
            m_result_dual  <= res_dual_next;
            m_is_equal     <= sb.eq;
            m_divide_error <= sb.derr;
            m_overflow     <= ovf_next;
        end
    end

    `DNA_ZERO_WHEN(a_derr_zero, m_divide_error, "divide error beat with nonzero parts")
    `DNA_ZERO_WHEN(a_eq_zero, m_is_equal, "compare beat with nonzero parts")
    `DNA_ASSERT(a_flags_excl, m_valid |-> !(m_is_equal && m_divide_error), "flags both set")

endmodule
